FILE: rtl/core/msfd_pkg.sv
// shared types and constants for the mode s field decoder
// no dependencies
package msfd_pkg;

  localparam logic [23:0] GEN_LOW = 24'hFFF409;
  localparam int STORE_DEPTH = 14;

  typedef enum logic [1:0] {ST_OK = 2'd0, ST_LEN = 2'd1, ST_PAR = 2'd2} status_t;

  typedef enum logic [2:0] {
    CT_NONE = 3'd0, CT_ALT = 3'd1, CT_SQK = 3'd2, CT_CALL = 3'd3,
    CT_VEL = 3'd4, CT_SURF = 3'd5, CT_AIRP = 3'd6
  } content_t;

  // one finished message handed from front to back
  typedef struct packed {
    logic [111:0] msg;
    logic [3:0]   len;
    logic [23:0]  parity;
  } msg_rec_t;

  // fold one byte into the parity remainder
  function automatic logic [23:0] fold_byte(input logic [23:0] acc, input logic [7:0] b);
    logic [23:0] a;
    logic        top;
    a = acc;
    for (int k = 7; k >= 0; k--) begin
      top = a[23];
      a = {a[22:0], b[k]};
      if (top) a = a ^ GEN_LOW;
    end
    return a;
  endfunction

  // callsign character map, zero means skipped
  function automatic logic [7:0] char_map(input logic [5:0] c);
    logic [7:0] r;
    r = 8'd0;
    if (c >= 6'd1 && c <= 6'd26) r = 8'd64 + {2'b00, c};
    else if (c == 6'd32) r = 8'd32;
    else if (c >= 6'd48 && c <= 6'd57) r = {2'b00, c};
    return r;
  endfunction

  function automatic logic [15:0] surface_movement(input logic [6:0] v);
    logic [15:0] r;
    logic [15:0] x;
    x = {9'd0, v};
    if (v == 7'd1) r = 16'd0;
    else if (v >= 7'd2 && v <= 7'd8) r = x - 16'd1;
    else if (v >= 7'd9 && v <= 7'd12) r = 16'd8 + ((x - 16'd8) << 1);
    else if (v >= 7'd13 && v <= 7'd38) r = 16'd16 + ((x - 16'd12) << 2);
    else if (v >= 7'd39 && v <= 7'd93) r = 16'd120 + ((x - 16'd38) << 3);
    else if (v >= 7'd94 && v <= 7'd108) r = 16'd560 + ((x - 16'd93) << 4);
    else if (v >= 7'd109 && v <= 7'd123) r = 16'd800 + 16'(40 * (x - 16'd108));
    else if (v == 7'd124) r = 16'd1400;
    else r = 16'hFFFF;
    return r;
  endfunction

endpackage

FILE: rtl/core/msfd_front.sv
// front: collects bytes, byte count and running parity
// depends on msfd_pkg
module msfd_front import msfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] rx_byte,
  input  logic       last_byte,
  output logic       rec_valid,
  output msg_rec_t   rec
);

  logic [7:0]  store [STORE_DEPTH];
  logic [3:0]  byte_count;
  logic [23:0] parity;
  logic [3:0]  count_next;
  logic [23:0] parity_next;
  logic [111:0] flat;

  always_comb begin
    count_next = (byte_count < 4'd15) ? byte_count + 4'd1 : byte_count;
    parity_next = (byte_count < 4'(STORE_DEPTH)) ? fold_byte(parity, rx_byte) : parity;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (byte_count == 4'(i)) flat[111-8*i -: 8] = rx_byte;
      else flat[111-8*i -: 8] = store[i];
    end
  end

  // byte store, written in place
  always_ff @(posedge clk) begin
    if (start && byte_count < 4'(STORE_DEPTH)) store[byte_count] <= rx_byte;
    if (start && last_byte) begin
      rec.msg <= flat;
      rec.len <= count_next;
      rec.parity <= parity_next;
    end
  end

  // count, parity and handoff
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      parity <= '0;
      rec_valid <= 1'b0;
    end else begin
      rec_valid <= start && last_byte;
      if (start) begin
        if (last_byte) begin
          byte_count <= '0;
          parity <= '0;
        end else begin
          byte_count <= count_next;
          parity <= parity_next;
        end
      end
    end
  end

endmodule

FILE: rtl/core/msfd_back.sv
// back: decodes one finished message into a record
// depends on msfd_pkg
module msfd_back import msfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  input  msg_rec_t           rec,
  output logic               done,
  output logic [1:0]         status,
  output logic [4:0]         downlink_format,
  output logic [23:0]        aircraft_address,
  output logic [2:0]         content,
  output logic [1:0]         airborne_state,
  output logic signed [16:0] altitude_feet,
  output logic               altitude_valid,
  output logic [63:0]        identity_word,
  output logic signed [17:0] first_value,
  output logic signed [17:0] second_value,
  output logic signed [15:0] third_value,
  output logic [11:0]        flag_bits
);

  logic [111:0] m;
  logic [4:0] df;
  logic [7:0] m2, m3, m5, m6;
  logic [1:0] st_n;
  logic [23:0] addr_n;
  logic [2:0] ct_n;
  logic [1:0] air_n;
  logic [16:0] alt_n;
  logic altv_n;
  logic [63:0] id_n;
  logic [17:0] v1_n, v2_n;
  logic [15:0] v3_n;
  logic [11:0] fl_n;
  logic [4:0] tc;
  logic [2:0] st, ca;
  logic [9:0] ew, ns;
  logic [8:0] vr;
  logic [10:0] n11;
  logic [2:0] sa, sb, sc, sd;
  logic [13:0] sq;
  logic [63:0] cw;
  logic [7:0] ch;

  always_comb begin
    m = rec.msg;
    df = m[111:107];
    m2 = m[95:88]; m3 = m[87:80]; m5 = m[71:64]; m6 = m[63:56];
    ca = m[106:104];
    tc = m[79:75];
    st = m[74:72];
    ew = m[65:56]; ns = m[54:45]; vr = m[42:34];
    st_n = ST_OK; addr_n = '0; ct_n = CT_NONE; air_n = 2'd2; alt_n = '0; altv_n = 1'b0;
    id_n = '0; v1_n = '0; v2_n = '0; v3_n = 16'hFFFF; fl_n = '0;
    n11 = '0;
    sa = {m3[7], m2[1], m2[3]};
    sb = {m3[1], m3[3], m3[5]};
    sc = {m2[0], m2[2], m2[4]};
    sd = {m3[0], m3[2], m3[4]};
    sq = {11'd0, sa} * 14'd1000 + {11'd0, sb} * 14'd100 + {11'd0, sc} * 14'd10
       + {11'd0, sd};
    // callsign packing, skipped characters close up
    cw = '0;
    for (int i = 0; i < 8; i++) begin
      ch = char_map(m[71-6*i -: 6]);
      if (ch != 8'd0) cw = {cw[55:0], ch};
    end
    for (int i = 0; i < 8; i++) if (cw[63:56] == 8'd0 && cw != '0) cw = cw << 8;
    if (rec.len != (df[4] ? 4'd14 : 4'd7)) begin
      st_n = ST_LEN;
    end else if (df == 5'd0 || df == 5'd4 || df == 5'd20) begin
      addr_n = rec.parity; ct_n = CT_ALT;
      if (!m3[6] && m3[4]) begin
        n11 = {m2[4:0], m3[7], m3[5], m3[3:0]};
        alt_n = 17'(25 * {6'd0, n11}) - 17'd1000;
        altv_n = 1'b1;
      end
    end else if (df == 5'd5 || df == 5'd21) begin
      addr_n = rec.parity; ct_n = CT_SQK;
      id_n = {50'd0, sq};
    end else if (df == 5'd11) begin
      addr_n = m[103:80];
      if (ca == 3'd4) air_n = 2'd0;
      else if (ca == 3'd5) air_n = 2'd1;
      if (rec.parity != '0) st_n = ST_PAR;
    end else if (df == 5'd17 || df == 5'd18) begin
      addr_n = m[103:80];
      if (rec.parity != '0) st_n = ST_PAR;
      else if (tc >= 5'd1 && tc <= 5'd4) begin
        ct_n = CT_CALL; id_n = cw;
      end else if (tc == 5'd19) begin
        if (st == 3'd1 || st == 3'd2) begin
          ct_n = CT_VEL; air_n = 2'd1;
          if (ew != '0 && ns != '0) begin
            v1_n = m[66] ? 18'(-({8'd0, ew} - 18'd1)) : {8'd0, ew} - 18'd1;
            v2_n = m[55] ? 18'(-({8'd0, ns} - 18'd1)) : {8'd0, ns} - 18'd1;
            fl_n[2] = 1'b1;
            if (st == 3'd2) fl_n[1] = 1'b1;
          end
          if (vr != '0) begin
            v3_n = 16'({7'd0, vr} - 16'd1) << 6;
            if (m[43]) v3_n = -v3_n;
            fl_n[3] = 1'b1;
          end
        end
      end else if (tc >= 5'd5 && tc <= 5'd18) begin
        if (tc <= 5'd8) begin
          ct_n = CT_SURF; air_n = 2'd0;
          if (m[67]) fl_n[11:4] = {m[66:60], 1'b1};
          v3_n = surface_movement(m[74:68]);
        end else begin
          ct_n = CT_AIRP; air_n = 2'd1;
          if (m5[0]) begin
            n11 = {m5[7:1], m6[7:4]};
            alt_n = 17'(25 * {6'd0, n11}) - 17'd1000;
            altv_n = 1'b1;
          end
        end
        fl_n[0] = m[58];
        v1_n = {1'b0, m[57:41]};
        v2_n = {1'b0, m[40:24]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= rec_valid;
    if (rec_valid) begin
      status <= st_n; downlink_format <= df; aircraft_address <= addr_n;
      content <= ct_n; airborne_state <= air_n; altitude_feet <= alt_n;
      altitude_valid <= altv_n; identity_word <= id_n; first_value <= v1_n;
      second_value <= v2_n; third_value <= v3_n; flag_bits <= fl_n;
    end
  end

`ifndef SYNTHESIS
  a_done: assert property (@(posedge clk) disable iff (rst) rec_valid |=> done)
    else $error("record lost");
  a_nodone: assert property (@(posedge clk) disable iff (rst) !rec_valid |=> !done)
    else $error("spurious record");
  a_st: assert property (@(posedge clk) disable iff (rst) done |-> status != 2'd3)
    else $error("bad status");
`endif

endmodule

FILE: rtl/core/mode_s_message_field_decoder.sv
// top level of the mode s field decoder: one byte per cycle; the record
// is registered in the front, then in the back, after the request carrying last_byte; never busy.
// throughput one byte per cycle; synchronous reset clears count and parity.
// the receiver cannot stall; each record shows for one cycle on done
module mode_s_message_field_decoder import msfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         rx_byte,
  input  logic               last_byte,
  output logic               done,
  output logic [1:0]         status,
  output logic [4:0]         downlink_format,
  output logic [23:0]        aircraft_address,
  output logic [2:0]         content,
  output logic [1:0]         airborne_state,
  output logic signed [16:0] altitude_feet,
  output logic               altitude_valid,
  output logic [63:0]        identity_word,
  output logic signed [17:0] first_value,
  output logic signed [17:0] second_value,
  output logic signed [15:0] third_value,
  output logic [11:0]        flag_bits
);

  logic rec_valid;
  msg_rec_t rec;

  assign busy = 1'b0;

  msfd_front u_front (.clk, .rst, .start, .rx_byte, .last_byte, .rec_valid, .rec);
  msfd_back u_back (.clk, .rst, .rec_valid, .rec, .done, .status, .downlink_format,
    .aircraft_address, .content, .airborne_state, .altitude_feet, .altitude_valid,
    .identity_word, .first_value, .second_value, .third_value, .flag_bits);

endmodule

FILE: dv/tb.sv
// testbench for the mode s field decoder: byte requests in, one record per message out
// depends on msfd_pkg and mode_s_message_field_decoder from the rtl
`timescale 1ns / 1ps

module tb;
  import msfd_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  df;
    logic [23:0] addr;
    logic [2:0]  content;
    logic [1:0]  air;
    logic [16:0] alt;
    logic        altv;
    logic [63:0] ident;
    logic [17:0] v1;
    logic [17:0] v2;
    logic [15:0] v3;
    logic [11:0] flags;
  } record_t;

  logic clk, rst, start, last_byte;
  logic [7:0] rx_byte;
  logic busy, done;
  logic [1:0] status;
  logic [4:0] downlink_format;
  logic [23:0] aircraft_address;
  logic [2:0] content;
  logic [1:0] airborne_state;
  logic signed [16:0] altitude_feet;
  logic altitude_valid;
  logic [63:0] identity_word;
  logic signed [17:0] first_value, second_value;
  logic signed [15:0] third_value;
  logic [11:0] flag_bits;

  // predictor state
  logic [7:0]  byte_store [STORE_DEPTH];
  logic [3:0]  byte_cnt;
  logic [23:0] crc_rem;
  record_t     expected_records [$];
  int          err_cnt, bytes_sent, msgs_sent, records_seen;
  logic [7:0]  frame [18];

  mode_s_message_field_decoder u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .rx_byte(rx_byte),
    .last_byte(last_byte), .done(done), .status(status),
    .downlink_format(downlink_format), .aircraft_address(aircraft_address),
    .content(content), .airborne_state(airborne_state),
    .altitude_feet(altitude_feet), .altitude_valid(altitude_valid),
    .identity_word(identity_word), .first_value(first_value),
    .second_value(second_value), .third_value(third_value), .flag_bits(flag_bits)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // bit-serial remainder over generator 0x1FFF409
  function automatic logic [23:0] crc_fold(input logic [23:0] acc, input logic [7:0] b);
    logic [23:0] a;
    logic        msb;
    a = acc;
    for (int k = 7; k >= 0; k--) begin
      msb = a[23];
      a = {a[22:0], b[k]};
      if (msb) a = a ^ 24'hFFF409;
    end
    return a;
  endfunction

  function automatic logic [31:0] bits_at(input logic [111:0] v, input int pos, input int n);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r = {r[30:0], v[111 - pos - i]};
    return r;
  endfunction

  function automatic logic [7:0] callsign_char(input logic [5:0] c);
    logic [7:0] r;
    r = 8'd0;
    if (c >= 1 && c <= 26) r = 8'h40 | {2'b00, c};
    else if (c == 32 || (c >= 48 && c <= 57)) r = {2'b00, c};
    return r;
  endfunction

  function automatic int ground_speed_eighths(input int v);
    int r;
    if (v == 1) r = 0;
    else if (v >= 2 && v <= 8) r = v - 1;
    else if (v >= 9 && v <= 12) r = 8 + 2 * (v - 8);
    else if (v >= 13 && v <= 38) r = 16 + 4 * (v - 12);
    else if (v >= 39 && v <= 93) r = 120 + 8 * (v - 38);
    else if (v >= 94 && v <= 108) r = 560 + 16 * (v - 93);
    else if (v >= 109 && v <= 123) r = 800 + 40 * (v - 108);
    else if (v == 124) r = 1400;
    else r = -1;
    return r;
  endfunction

  // decode the stored message into the record the block should emit
  function automatic record_t decode_message();
    record_t r;
    logic [111:0] mv;
    logic [7:0] m2, m3, m5, m6, ch;
    logic [4:0] df;
    logic [63:0] cs;
    int need, tc, st, ew, ns, vr, a, bb, c, d, nalt, v1, v2, v3, alt, nch;
    for (int i = 0; i < STORE_DEPTH; i++) mv[111 - 8*i -: 8] = byte_store[i];
    df = mv[111:107];
    m2 = byte_store[2]; m3 = byte_store[3]; m5 = byte_store[5]; m6 = byte_store[6];
    need = df[4] ? 14 : 7;
    r = '0;
    r.df = df; r.air = 2'd2;
    v1 = 0; v2 = 0; v3 = -1; alt = 0;
    if (byte_cnt != need) begin
      r.status = ST_LEN;
    end else if (df == 0 || df == 4 || df == 20) begin
      r.addr = crc_rem; r.content = CT_ALT;
      if (!m3[6] && m3[4]) begin
        nalt = int'({m2[4:0], m3[7], m3[5], m3[3:0]});
        alt = nalt * 25 - 1000; r.altv = 1'b1;
      end
    end else if (df == 5 || df == 21) begin
      a  = int'({m3[7], m2[1], m2[3]});
      bb = int'({m3[1], m3[3], m3[5]});
      c  = int'({m2[0], m2[2], m2[4]});
      d  = int'({m3[0], m3[2], m3[4]});
      r.addr = crc_rem; r.content = CT_SQK;
      r.ident = 64'(a * 1000 + bb * 100 + c * 10 + d);
    end else if (df == 11) begin
      r.addr = 24'(bits_at(mv, 8, 24));
      if (bits_at(mv, 5, 3) == 4) r.air = 2'd0;
      else if (bits_at(mv, 5, 3) == 5) r.air = 2'd1;
      if (crc_rem != 0) r.status = ST_PAR;
    end else if (df == 17 || df == 18) begin
      r.addr = 24'(bits_at(mv, 8, 24));
      if (crc_rem != 0) begin
        r.status = ST_PAR;
      end else begin
        tc = bits_at(mv, 32, 5);
        st = bits_at(mv, 37, 3);
        if (tc >= 1 && tc <= 4) begin
          r.content = CT_CALL;
          cs = '0; nch = 0;
          for (int i = 0; i < 8; i++) begin
            ch = callsign_char(6'(bits_at(mv, 40 + 6*i, 6)));
            if (ch != 0) begin
              cs = {cs[55:0], ch}; nch++;
            end
          end
          if (nch > 0 && nch < 8) cs = cs << (8 * (8 - nch));
          r.ident = cs;
        end else if (tc == 19) begin
          if (st == 1 || st == 2) begin
            ew = bits_at(mv, 46, 10);
            ns = bits_at(mv, 57, 10);
            vr = bits_at(mv, 69, 9);
            r.content = CT_VEL; r.air = 2'd1;
            if (ew != 0 && ns != 0) begin
              v1 = bits_at(mv, 45, 1) ? -(ew - 1) : (ew - 1);
              v2 = bits_at(mv, 56, 1) ? -(ns - 1) : (ns - 1);
              r.flags[2] = 1'b1;
              if (st == 2) r.flags[1] = 1'b1;
            end
            if (vr != 0) begin
              v3 = (vr - 1) * 64;
              if (bits_at(mv, 68, 1)) v3 = -v3;
              r.flags[3] = 1'b1;
            end
          end
        end else if (tc >= 5 && tc <= 18) begin
          if (tc <= 8) begin
            r.content = CT_SURF; r.air = 2'd0;
            if (bits_at(mv, 44, 1)) begin
              r.flags[4] = 1'b1;
              r.flags[11:5] = 7'(bits_at(mv, 45, 7));
            end
            v3 = ground_speed_eighths(int'(bits_at(mv, 37, 7)));
          end else begin
            r.content = CT_AIRP; r.air = 2'd1;
            if (m5[0]) begin
              nalt = int'({m5[7:1], m6[7:4]});
              alt = nalt * 25 - 1000; r.altv = 1'b1;
            end
          end
          r.flags[0] = 1'(bits_at(mv, 53, 1));
          v1 = bits_at(mv, 54, 17);
          v2 = bits_at(mv, 71, 17);
        end
      end
    end
    r.alt = alt[16:0]; r.v1 = v1[17:0]; r.v2 = v2[17:0]; r.v3 = v3[15:0];
    return r;
  endfunction

  // advance the predictor by one accepted byte
  task automatic absorb_byte(input logic [7:0] b, input logic lst);
    if (byte_cnt < STORE_DEPTH) begin
      byte_store[byte_cnt] = b;
      crc_rem = crc_fold(crc_rem, b);
    end
    if (byte_cnt < 15) byte_cnt++;
    if (lst) begin
      expected_records.push_back(decode_message());
      byte_cnt = 0;
      crc_rem = '0;
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // send one byte request and wait for acceptance
  task automatic send_byte(input logic [7:0] b, input logic lst, input int gap);
    start <= 1'b1;
    rx_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_byte(b, lst);
    bytes_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      rx_byte <= 8'($urandom);
      last_byte <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input int n, input logic bursty);
    for (int i = 0; i < n; i++)
      send_byte(frame[i], i == n - 1, bursty ? 0 : pick_gap());
    msgs_sent++;
  endtask

  // write parity over the first n-3 bytes into the last three
  task automatic seal_frame(input int n);
    logic [23:0] acc;
    acc = '0;
    for (int i = 0; i < n - 3; i++) acc = crc_fold(acc, frame[i]);
    repeat (3) acc = crc_fold(acc, 8'h00);
    {frame[n-3], frame[n-2], frame[n-1]} = acc;
  endtask

  task automatic fill_random(input int n);
    for (int i = 0; i < n; i++) frame[i] = 8'($urandom);
  endtask

  // extremes: all-zero altitude reply, all-ones squawk, sealed all-call
  task automatic test_directed();
    fill_random(7);
    frame[0] = {5'd4, 3'd0};
    frame[2] = 8'h00; frame[3] = 8'h10;
    send_frame(7, 1'b0);
    for (int i = 0; i < 7; i++) frame[i] = 8'hFF;
    frame[0] = {5'd5, 3'd7};
    send_frame(7, 1'b1);
    fill_random(7);
    frame[0] = {5'd11, 3'd5};
    seal_frame(7);
    send_frame(7, 1'b0);
  endtask

  task automatic make_squitter();
    int p, tc;
    fill_random(14);
    frame[0][7:3] = ($urandom_range(1)) ? 5'd17 : 5'd18;
    p = $urandom_range(99);
    if (p < 20) tc = $urandom_range(1, 4);
    else if (p < 45) tc = 19;
    else if (p < 60) tc = $urandom_range(5, 8);
    else if (p < 85) tc = $urandom_range(9, 18);
    else tc = ($urandom_range(3) == 0) ? 0 : $urandom_range(20, 31);
    frame[4][7:3] = 5'(tc);
    if (tc == 19 && $urandom_range(3) != 0) frame[4][2:0] = 3'($urandom_range(1, 2));
    // zero velocity or rate fields now and then
    if (tc == 19 && $urandom_range(5) == 0) begin
      frame[5][1:0] = 2'b00; frame[6] = 8'h00;
    end
    if (tc == 19 && $urandom_range(5) == 0) begin
      frame[8][2:0] = 3'b000; frame[9][7:2] = 6'd0;
    end
    if (tc >= 5 && tc <= 8 && $urandom_range(4) == 0)
      frame[4][2:0] = 3'b111;
    seal_frame(14);
    if ($urandom_range(9) == 0) frame[$urandom_range(13)][$urandom_range(7)] ^= 1'b1;
  endtask

  task automatic test_extended_squitter(input int nbytes);
    int stop;
    stop = bytes_sent + nbytes;
    while (bytes_sent < stop) begin
      make_squitter();
      send_frame(14, $urandom_range(3) == 0);
    end
  endtask

  task automatic test_short_replies(input int nbytes);
    int stop, k, n;
    logic [4:0] fmt [6];
    fmt = '{5'd0, 5'd4, 5'd5, 5'd11, 5'd20, 5'd21};
    stop = bytes_sent + nbytes;
    while (bytes_sent < stop) begin
      k = $urandom_range(5);
      n = fmt[k][4] ? 14 : 7;
      fill_random(n);
      frame[0][7:3] = fmt[k];
      if (fmt[k] == 11) begin
        seal_frame(7);
        if ($urandom_range(7) == 0) frame[$urandom_range(6)][$urandom_range(7)] ^= 1'b1;
      end
      send_frame(n, $urandom_range(3) == 0);
    end
  endtask

  // random formats, wrong lengths and overlong messages
  task automatic test_malformed(input int nbytes);
    int stop, n, p;
    stop = bytes_sent + nbytes;
    while (bytes_sent < stop) begin
      p = $urandom_range(9);
      if (p < 4) n = $urandom_range(1, 14);
      else if (p < 7) n = $urandom_range(15, 18);
      else n = $urandom_range(1) ? 14 : 7;
      fill_random(n);
      send_frame(n, 1'b0);
    end
  endtask

  // record checker
  always @(posedge clk) begin
    record_t e;
    if (!rst && done) begin
      records_seen++;
      if (expected_records.size() == 0) begin
        $error("record with no message pending");
        err_cnt++;
      end else begin
        e = expected_records.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); err_cnt++;
        end
        if (downlink_format !== e.df) begin
          $error("downlink_format exp %0d got %0d", e.df, downlink_format); err_cnt++;
        end
        if (aircraft_address !== e.addr) begin
          $error("aircraft_address exp %h got %h", e.addr, aircraft_address); err_cnt++;
        end
        if (content !== e.content) begin
          $error("content exp %0d got %0d", e.content, content); err_cnt++;
        end
        if (airborne_state !== e.air) begin
          $error("airborne_state exp %0d got %0d", e.air, airborne_state); err_cnt++;
        end
        if (altitude_feet !== e.alt) begin
          $error("altitude_feet exp %h got %h", e.alt, altitude_feet); err_cnt++;
        end
        if (altitude_valid !== e.altv) begin
          $error("altitude_valid exp %0d got %0d", e.altv, altitude_valid); err_cnt++;
        end
        if (identity_word !== e.ident) begin
          $error("identity_word exp %h got %h", e.ident, identity_word); err_cnt++;
        end
        if (first_value !== e.v1) begin
          $error("first_value exp %h got %h", e.v1, first_value); err_cnt++;
        end
        if (second_value !== e.v2) begin
          $error("second_value exp %h got %h", e.v2, second_value); err_cnt++;
        end
        if (third_value !== e.v3) begin
          $error("third_value exp %h got %h", e.v3, third_value); err_cnt++;
        end
        if (flag_bits !== e.flags) begin
          $error("flag_bits exp %h got %h", e.flags, flag_bits); err_cnt++;
        end
      end
    end
  end

  initial begin
    int wait_cnt;
    rst = 1'b1; start = 1'b0; rx_byte = '0; last_byte = 1'b0;
    byte_cnt = '0; crc_rem = '0;
    err_cnt = 0; bytes_sent = 0; msgs_sent = 0; records_seen = 0;
    for (int i = 0; i < STORE_DEPTH; i++) byte_store[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extended_squitter(650);
    test_short_replies(400);
    test_malformed(400);
    start <= 1'b0;
    last_byte <= 1'b0;
    wait_cnt = 0;
    while (expected_records.size() != 0 && wait_cnt < 1000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (10) @(posedge clk);
    if (expected_records.size() != 0) begin
      $error("%0d records never arrived", expected_records.size());
      err_cnt++;
    end
    $display("sent %0d bytes in %0d messages, checked %0d records", bytes_sent, msgs_sent,
             records_seen);
    $display("covered squitters, short replies, parity faults, bad and overlong lengths");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: mode_s_message_field_decoder.f
rtl/core/msfd_pkg.sv
rtl/core/msfd_front.sv
rtl/core/msfd_back.sv
rtl/core/mode_s_message_field_decoder.sv
dv/tb.sv
